FILE: design/pcts_pkg.sv
// Shared types and constants for the priority credit thread scheduler.
package pcts_pkg;

    localparam int THREADS  = 64;
    localparam int TID_W    = 6;
    localparam int LEVELS   = 6;
    localparam int LV_W     = 3;
    localparam int CNT_W    = 7;
    localparam int CRED_W   = 8;
    localparam int PCLASSES = 3;

    localparam logic [LV_W-1:0] LV_STRICT1   = 3'd1;
    localparam logic [LV_W-1:0] LV_PROP_LO   = 3'd2;
    localparam logic [LV_W-1:0] LV_PROP_MID  = 3'd3;
    localparam logic [LV_W-1:0] LV_PROP_HI   = 3'd4;
    localparam logic [LV_W-1:0] LV_IDLE      = 3'd5;
    localparam logic [LV_W-1:0] PRIO_RESET   = 3'd3;

    localparam logic [CRED_W-1:0] RELOAD0_RST = 8'd12;
    localparam logic [CRED_W-1:0] RELOAD1_RST = 8'd5;
    localparam logic [CRED_W-1:0] RELOAD2_RST = 8'd2;

    localparam logic [1:0] REG_CREDITS_INTERACTIVE = 2'd0;
    localparam logic [1:0] REG_CREDITS_NORMAL      = 2'd1;
    localparam logic [1:0] REG_CREDITS_BACKGROUND  = 2'd2;

    typedef enum logic [1:0] {
        OP_WAKE       = 2'd0,
        OP_SLEEP      = 2'd1,
        OP_SET_PRIO   = 2'd2,
        OP_RESCHEDULE = 2'd3
    } t_opcode;

    typedef struct packed {
        logic info_wr;
        logic info_awake;
        logic info_set_np;
        logic load_info;
        logic cnt_inc;
        logic cnt_dec;
        logic run_ctx;
        logic prio_upd;
        logic rm_wr;
        logic append;
        logic pick;
        logic out_load;
        logic did_pick;
    } t_cmd;

    typedef struct packed {
        logic info_awake;
        logic np_ok;
        logic preempt;
        logic t_is_run;
        logic run_flag;
        logic out_free;
    } t_sts;

endpackage

FILE: design/pcts_ctrl.sv
// Operation sequencer for the scheduler: decodes each transaction into datapath steps.
module pcts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [1:0]      i_op,
    input  pcts_pkg::t_sts  i_sts,
    output logic            o_ready,
    output pcts_pkg::t_cmd  o_cmd
);
    import pcts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INFO, S_RM_RD, S_RM_WR, S_APPEND, S_PICK, S_DONE
    } t_state;

    typedef enum logic [1:0] { NX_DONE, NX_APPEND, NX_PICK, NX_PREEMPT } t_next;

    t_state  r_state, n_state;
    t_opcode r_op, n_op;
    t_next   r_after_rm, n_after_rm;
    t_next   r_after_ap, n_after_ap;
    logic    r_did, n_did;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_after_rm = r_after_rm;
        n_after_ap = r_after_ap;
        n_did      = r_did;
        o_cmd      = '0;
        o_cmd.did_pick = r_did;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_op    = t_opcode'(i_op);
                    n_did   = 1'b0;
                    n_state = S_INFO;
                end
            end
            S_INFO: begin
                unique case (r_op)
                    OP_RESCHEDULE: begin
                        n_did = 1'b1;
                        if (i_sts.run_flag) begin
                            o_cmd.run_ctx = 1'b1;
                            n_after_rm    = NX_APPEND;
                            n_after_ap    = NX_PICK;
                            n_state       = S_RM_RD;
                        end else begin
                            n_state = S_PICK;
                        end
                    end
                    OP_WAKE: begin
                        if (i_sts.info_awake) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.info_wr    = 1'b1;
                            o_cmd.info_awake = 1'b1;
                            o_cmd.load_info  = 1'b1;
                            o_cmd.cnt_inc    = 1'b1;
                            n_after_ap       = NX_PREEMPT;
                            n_state          = S_APPEND;
                        end
                    end
                    OP_SLEEP: begin
                        if (!i_sts.info_awake) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.info_wr   = 1'b1;
                            o_cmd.load_info = 1'b1;
                            o_cmd.cnt_dec   = 1'b1;
                            // the running thread leaves: pick without rotation
                            n_did      = i_sts.run_flag && i_sts.t_is_run;
                            n_after_rm = (i_sts.run_flag && i_sts.t_is_run) ? NX_PICK : NX_DONE;
                            n_state    = S_RM_RD;
                        end
                    end
                    OP_SET_PRIO: begin
                        if (!i_sts.np_ok) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.info_wr     = 1'b1;
                            o_cmd.info_awake  = i_sts.info_awake;
                            o_cmd.info_set_np = 1'b1;
                            o_cmd.load_info   = 1'b1;
                            o_cmd.prio_upd    = 1'b1;
                            n_after_rm        = NX_APPEND;
                            n_after_ap        = NX_DONE;
                            n_state           = i_sts.info_awake ? S_RM_RD : S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RM_RD: n_state = S_RM_WR;
            S_RM_WR: begin
                o_cmd.rm_wr = 1'b1;
                priority case (r_after_rm)
                    NX_APPEND: n_state = S_APPEND;
                    NX_PICK:   n_state = S_PICK;
                    default:   n_state = S_DONE;
                endcase
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                priority case (r_after_ap)
                    NX_PICK: n_state = S_PICK;
                    NX_PREEMPT: begin
                        if (i_sts.preempt) begin
                            o_cmd.run_ctx = 1'b1;
                            n_did         = 1'b1;
                            n_after_rm    = NX_APPEND;
                            n_after_ap    = NX_PICK;
                            n_state       = S_RM_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_WAKE;
            r_after_rm <= NX_DONE;
            r_after_ap <= NX_DONE;
            r_did      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_after_rm <= n_after_rm;
            r_after_ap <= n_after_ap;
            r_did      <= n_did;
        end
    end

endmodule

FILE: design/pcts_dp.sv
// Scheduler datapath: thread and link memories, queue registers, credits, pick and output.
module pcts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcts_pkg::t_cmd                i_cmd,
    output pcts_pkg::t_sts                o_sts,
    input  logic                          i_accept,
    input  logic [pcts_pkg::TID_W-1:0]    i_tid,
    input  logic [pcts_pkg::LV_W-1:0]     i_np,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [pcts_pkg::CRED_W-1:0]   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [15:0]                   o_out_data
);
    import pcts_pkg::*;

    logic [LV_W:0]       info_mem [THREADS];
    logic [THREADS-1:0]  r_info_vld;
    logic [LV_W:0]       r_info_q;
    logic                r_info_qv;
    logic [TID_W-1:0]    next_mem [THREADS];
    logic [TID_W-1:0]    prev_mem [THREADS];
    logic [TID_W-1:0]    r_nxt_q, r_prv_q;

    logic [TID_W-1:0]    r_head [LEVELS];
    logic [TID_W-1:0]    r_tail [LEVELS];
    logic [CNT_W-1:0]    r_cnt  [LEVELS];
    logic [CRED_W-1:0]   r_credit [PCLASSES];
    logic [CRED_W-1:0]   r_reload [PCLASSES];

    logic [TID_W-1:0]    r_t, r_run;
    logic [LV_W-1:0]     r_np, r_lv_old, r_lv_new, r_run_prio;
    logic                r_run_flag;
    logic [CNT_W-1:0]    r_awake_cnt;
    logic                r_out_valid;
    logic [15:0]         r_out_data;

    logic [LV_W-1:0]     info_prio;
    logic                info_awake;
    logic [1:0]          cls_new;
    logic                timeslice;
    logic [CNT_W+1:0]    prop_sum;

    // pick results
    logic                pk_flag;
    logic [TID_W-1:0]    pk_id;
    logic [LV_W-1:0]     pk_lv;
    logic [CRED_W-1:0]   pk_credit [PCLASSES];
    logic [PCLASSES-1:0] c_ok, r_ok;
    logic                any_prop;

    assign info_prio  = r_info_qv ? r_info_q[LV_W:1] : PRIO_RESET;
    assign info_awake = r_info_qv ? r_info_q[0] : 1'b0;
    assign cls_new    = 2'(r_lv_new - LV_PROP_LO);

    assign o_sts.info_awake = info_awake;
    assign o_sts.np_ok      = (r_np <= LV_IDLE) && (r_np != info_prio);
    assign o_sts.t_is_run   = (r_t == r_run);
    assign o_sts.run_flag   = r_run_flag;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.preempt    = r_run_flag && (r_lv_new < r_run_prio) &&
                              ((r_lv_new <= LV_STRICT1) ||
                               ((r_lv_new <= LV_PROP_HI) && (r_credit[cls_new] != '0)));

    assign prop_sum = (CNT_W+2)'(r_cnt[2]) + (CNT_W+2)'(r_cnt[3]) + (CNT_W+2)'(r_cnt[4]);

    always_comb begin
        timeslice = 1'b0;
        if (r_run_flag) begin
            if (r_run_prio == LV_PROP_LO || r_run_prio == LV_PROP_MID ||
                r_run_prio == LV_PROP_HI) begin
                timeslice = prop_sum >= (CNT_W+2)'(2);
            end else begin
                timeslice = r_cnt[r_run_prio] >= CNT_W'(2);
            end
        end
    end

    assign any_prop = (r_cnt[2] != '0) || (r_cnt[3] != '0) || (r_cnt[4] != '0);
    assign c_ok[0]  = (r_cnt[2] != '0) && (r_credit[0] != '0);
    assign c_ok[1]  = (r_cnt[3] != '0) && (r_credit[1] != '0);
    assign c_ok[2]  = (r_cnt[4] != '0) && (r_credit[2] != '0);
    assign r_ok[0]  = (r_cnt[2] != '0) && (r_reload[0] != '0);
    assign r_ok[1]  = (r_cnt[3] != '0) && (r_reload[1] != '0);
    assign r_ok[2]  = (r_cnt[4] != '0) && (r_reload[2] != '0);

    always_comb begin
        pk_credit = r_credit;
        pk_flag   = 1'b1;
        pk_id     = '0;
        pk_lv     = PRIO_RESET;
        priority if (r_cnt[0] != '0) begin
            pk_id = r_head[0]; pk_lv = 3'd0;
        end else if (r_cnt[1] != '0) begin
            pk_id = r_head[1]; pk_lv = LV_STRICT1;
        end else if (c_ok[0]) begin
            pk_credit[0] = r_credit[0] - 8'd1; pk_id = r_head[2]; pk_lv = LV_PROP_LO;
        end else if (c_ok[1]) begin
            pk_credit[1] = r_credit[1] - 8'd1; pk_id = r_head[3]; pk_lv = LV_PROP_MID;
        end else if (c_ok[2]) begin
            pk_credit[2] = r_credit[2] - 8'd1; pk_id = r_head[4]; pk_lv = LV_PROP_HI;
        end else if (any_prop && r_ok[0]) begin
            // reload all classes, spend one
            pk_credit = r_reload; pk_credit[0] = r_reload[0] - 8'd1;
            pk_id = r_head[2]; pk_lv = LV_PROP_LO;
        end else if (any_prop && r_ok[1]) begin
            pk_credit = r_reload; pk_credit[1] = r_reload[1] - 8'd1;
            pk_id = r_head[3]; pk_lv = LV_PROP_MID;
        end else if (any_prop && r_ok[2]) begin
            pk_credit = r_reload; pk_credit[2] = r_reload[2] - 8'd1;
            pk_id = r_head[4]; pk_lv = LV_PROP_HI;
        end else begin
            if (any_prop) pk_credit = r_reload;
            if (r_cnt[5] != '0) begin
                pk_id = r_head[5]; pk_lv = LV_IDLE;
            end else begin
                pk_flag = 1'b0;
            end
        end
    end

    // thread info memory: {priority, awake}; unwritten entries read as reset values
    always_ff @(posedge i_clk) begin
        r_info_q <= info_mem[i_tid];
        if (i_cmd.info_wr) begin
            info_mem[r_t] <= {(i_cmd.info_set_np ? r_np : info_prio), i_cmd.info_awake};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_vld <= '0;
            r_info_qv  <= 1'b0;
        end else begin
            r_info_qv <= r_info_vld[i_tid] && !(i_cmd.info_wr && r_t == i_tid);
            if (i_cmd.info_wr) r_info_vld[r_t] <= 1'b1;
        end
    end

    // link memories: read at the current thread, write from remove or append
    always_ff @(posedge i_clk) begin
        r_nxt_q <= next_mem[r_t];
        r_prv_q <= prev_mem[r_t];
        if (i_cmd.rm_wr && r_cnt[r_lv_old] > CNT_W'(1)) begin
            if (r_t != r_head[r_lv_old]) next_mem[r_prv_q] <= r_nxt_q;
            if (r_t != r_tail[r_lv_old]) prev_mem[r_nxt_q] <= r_prv_q;
        end
        if (i_cmd.append && r_cnt[r_lv_new] != '0) begin
            next_mem[r_tail[r_lv_new]] <= r_t;
            prev_mem[r_t]              <= r_tail[r_lv_new];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_t  <= i_tid;
            r_np <= i_np;
        end else if (i_cmd.run_ctx) begin
            r_t <= r_run;
        end
        if (i_cmd.load_info) begin
            r_lv_old <= info_prio;
            r_lv_new <= i_cmd.info_set_np ? r_np : info_prio;
        end else if (i_cmd.run_ctx) begin
            r_lv_old <= r_run_prio;
            r_lv_new <= r_run_prio;
        end
        if (i_cmd.rm_wr && r_cnt[r_lv_old] > CNT_W'(1)) begin
            if (r_t == r_head[r_lv_old]) r_head[r_lv_old] <= r_nxt_q;
            if (r_t == r_tail[r_lv_old]) r_tail[r_lv_old] <= r_prv_q;
        end
        if (i_cmd.append) begin
            if (r_cnt[r_lv_new] == '0) r_head[r_lv_new] <= r_t;
            r_tail[r_lv_new] <= r_t;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_awake_cnt, timeslice, i_cmd.did_pick,
                           (r_run_flag ? r_run : TID_W'(0)), r_run_flag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) r_cnt[i] <= '0;
            r_reload[0] <= RELOAD0_RST;
            r_reload[1] <= RELOAD1_RST;
            r_reload[2] <= RELOAD2_RST;
            r_credit[0] <= RELOAD0_RST;
            r_credit[1] <= RELOAD1_RST;
            r_credit[2] <= RELOAD2_RST;
            r_run       <= '0;
            r_run_flag  <= 1'b0;
            r_run_prio  <= PRIO_RESET;
            r_awake_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CREDITS_INTERACTIVE: r_reload[0] <= i_cfg_data;
                    REG_CREDITS_NORMAL:      r_reload[1] <= i_cfg_data;
                    REG_CREDITS_BACKGROUND:  r_reload[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.cnt_inc) r_awake_cnt <= r_awake_cnt + CNT_W'(1);
            if (i_cmd.cnt_dec) r_awake_cnt <= r_awake_cnt - CNT_W'(1);
            if (i_cmd.rm_wr && r_cnt[r_lv_old] != '0) begin
                r_cnt[r_lv_old] <= r_cnt[r_lv_old] - CNT_W'(1);
            end
            if (i_cmd.append) r_cnt[r_lv_new] <= r_cnt[r_lv_new] + CNT_W'(1);
            if (i_cmd.prio_upd && r_t == r_run) r_run_prio <= r_np;
            if (i_cmd.pick) begin
                r_credit   <= pk_credit;
                r_run_flag <= pk_flag;
                r_run      <= pk_id;
                r_run_prio <= pk_lv;
            end
            if (i_cmd.out_load)  r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: design/priority_credit_thread_scheduler_top.sv
// Top level of the priority credit thread scheduler.
// One transaction in, one result out. An operation that changes nothing, or sets the
// priority of a sleeping thread, goes straight to its result; the others run the
// remove, append and pick steps that they need one after another before the result
// enters the output register. Each remove waits on the registered read port of the
// link memories. A new transaction is taken once the previous result sits in the
// output register.
// Configuration writes land at once; write only while the block is idle.
module priority_credit_thread_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // opcode[1:0], thread_id[7:2], new_priority[10:8], zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // running_valid[0], running_id[6:1], rescheduled[7],
                                     // needs_timeslice[8], awake_total[15:9]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import pcts_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic accept;

    assign accept = i_s_tvalid && o_s_tready;

    pcts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_s_tdata[1:0]),
        .i_sts    (sts),
        .o_ready  (o_s_tready),
        .o_cmd    (cmd)
    );

    pcts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_accept    (accept),
        .i_tid       (i_s_tdata[7:2]),
        .i_np        (i_s_tdata[10:8]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule

FILE: design/pcts_checker.sv
// Port-level checks for the scheduler top, attached by bind.
module pcts_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    // idle result carries no thread and no timeslice request
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[6:1] == 6'd0 && !o_m_tdata[8]))
        else $error("idle result with thread or timeslice set");

    a_awake_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:9] <= 7'd64))
        else $error("awake total out of range");

    // one transaction in flight: input closes right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an operation is in progress");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind priority_credit_thread_scheduler_top pcts_port_checks u_pcts_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
